[rtl/jlcp_pkg.sv]
// Shared types and constants for the joystick LED chaser with PWM dimming.
// Item structs, command and status structs, and the codes used by all modules.
// No dependencies.
`default_nettype none

package jlcp_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W    = 10;
  localparam int XVAL_W      = 11;
  localparam int COUNT_W     = 16;
  localparam int DIVIDEND_W  = 16;
  localparam int DIVISOR_W   = 10;
  localparam int MASK_W      = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Offset that centers the X conversion.
  localparam logic [XVAL_W-1:0] X_CENTER = 11'd512;

  // Item kinds.
  typedef enum logic [1:0] {
    MODE_ADC = 2'd0,
    MODE_PWM = 2'd1,
    MODE_MS  = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  // ADC channels in the order in which used conversions arrive.
  typedef enum logic [1:0] {
    CH_X = 2'd0,
    CH_Z = 2'd1,
    CH_Y = 2'd2
  } chan_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_TIME   = 3'd0,
    CFG_DEAD_BAND   = 3'd1,
    CFG_PAUSE_THR   = 3'd2,
    CFG_MOVE_THR    = 3'd3,
    CFG_PWM_PERIOD  = 3'd4,
    CFG_BRIGHT_DIV  = 3'd5,
    CFG_START_RIGHT = 3'd6,
    CFG_START_LED   = 3'd7
  } cfg_index_t;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_BRIGHT = 2'd0,  // Y sample / brightness divisor
    DIV_BAND   = 2'd1,  // |x| / dead band
    DIV_TIME   = 2'd2   // step time / previous quotient
  } div_sel_t;

  // Input item.
  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample;
  } jlcp_in_t;

  // Result item.
  typedef struct packed {
    logic [MASK_W-1:0] led_mask;
    logic [2:0]        active_led;
    logic              moving_right;
    logic              paused;
    logic [1:0]        next_channel;
  } jlcp_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     item_take;
    logic     apply;
    logic     div_start;
    div_sel_t div_sel;
    logic     on_load;
    logic     step_load;
    logic     out_load;
  } jlcp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_y_div;
    logic need_step_div;
    logic div_done;
  } jlcp_status_t;

endpackage

`default_nettype wire

[rtl/jlcp_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on jlcp_pkg for the operand widths.
`default_nettype none

module jlcp_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [jlcp_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [jlcp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                done,
  output logic [jlcp_pkg::DIVIDEND_W-1:0]      quotient
);
  import jlcp_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W);

  logic                  active;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  // One trial subtraction on the shifted remainder.
  always_comb begin
    rem_sh   = {rem, quotient[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dvsr};
    fits     = (rem_sh >= {1'b0, dvsr});
    rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        cnt      <= '0;
        quotient <= dividend;
        rem      <= '0;
        dvsr     <= divisor;
      end else if (active) begin
        rem      <= rem_next;
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(DIVIDEND_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/jlcp_datapath.sv]
// Datapath: configuration registers, chaser and PWM state, the shared divider
// and the result register. Depends on jlcp_pkg and jlcp_divider.
`default_nettype none

module jlcp_datapath #(
  parameter int LED_COUNT = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [jlcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [jlcp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire jlcp_pkg::jlcp_in_t               in_item,
  input  wire jlcp_pkg::jlcp_cmd_t              cmd,
  output jlcp_pkg::jlcp_status_t                status,
  output jlcp_pkg::jlcp_out_t                   out_item
);
  import jlcp_pkg::*;

  localparam int LW = $clog2(LED_COUNT);
  localparam int TW = 5;
  localparam logic [LW-1:0] LED_LAST = LW'(LED_COUNT - 1);

  // Configuration registers.
  logic [15:0] step_time_ms;
  logic [8:0]  dead_band;
  logic [9:0]  pause_threshold;
  logic [9:0]  move_threshold;
  logic [15:0] pwm_period;
  logic [9:0]  brightness_divisor;

  // Block state.
  logic [LW-1:0]      led_index;
  logic               heading_right;
  logic [COUNT_W-1:0] pwm_count;
  logic [9:0]         on_count;
  logic [XVAL_W-1:0]  x_value;
  logic [XVAL_W-1:0]  x_at_step;
  logic [9:0]         z_value;
  chan_t              adc_channel;
  logic               use_phase;
  logic [COUNT_W-1:0] wait_count;
  logic [COUNT_W-1:0] wait_target;
  logic               step_due;

  // Latched item.
  mode_t               item_mode;
  logic [SAMPLE_W-1:0] item_sample;

  // Reduce a start LED index below LED_COUNT; three subtractions cover any 3-bit value.
  function automatic logic [LW-1:0] led_wrap(input logic [2:0] v);
    logic [TW-1:0] t;
    t = TW'(v);
    for (int k = 0; k < 3; k++) begin
      if (t >= TW'(LED_COUNT)) t = t - TW'(LED_COUNT);
    end
    return t[LW-1:0];
  endfunction

  // Derived values used by the step rule.
  logic [8:0]         band;
  logic               x_neg;
  logic [XVAL_W-1:0]  x_negated;
  logic [9:0]         x_abs;
  logic               out_band;
  logic [XVAL_W:0]    dx;
  logic [XVAL_W:0]    dx_neg;
  logic [XVAL_W-1:0]  dx_abs;
  logic               dx_big;
  logic [COUNT_W-1:0] wait_inc;
  logic               step_cond;
  logic               paused_now;
  logic               dir_new;
  logic [LW-1:0]      led_next;

  always_comb begin
    band      = (dead_band == '0) ? 9'd1 : dead_band;
    x_neg     = x_value[XVAL_W-1];
    x_negated = -x_value;
    x_abs     = x_neg ? x_negated[9:0] : x_value[9:0];
    out_band  = (x_abs > {1'b0, band});
    dx        = {x_value[XVAL_W-1], x_value} - {x_at_step[XVAL_W-1], x_at_step};
    dx_neg    = -dx;
    dx_abs    = dx[XVAL_W] ? dx_neg[XVAL_W-1:0] : dx[XVAL_W-1:0];
    dx_big    = (dx_abs > {1'b0, move_threshold});
    wait_inc  = (wait_count != '1) ? wait_count + 1'b1 : wait_count;
    step_cond = step_due || dx_big || (wait_inc >= wait_target);
    paused_now = (z_value < pause_threshold);
  end

  // Direction and next LED for a step; the division path takes the sign of X.
  always_comb begin
    dir_new = cmd.step_load ? !x_neg : heading_right;
    if (dir_new) begin
      led_next = (led_index == '0) ? LED_LAST : led_index - 1'b1;
    end else begin
      led_next = (led_index == LED_LAST) ? '0 : led_index + 1'b1;
    end
  end

  // Status toward the controller, taken from the latched item.
  logic div_done;
  always_comb begin
    status               = '0;
    status.need_y_div    = (item_mode == MODE_ADC) && use_phase && (adc_channel == CH_Y);
    status.need_step_div = (item_mode == MODE_MS) && !paused_now && step_cond && out_band;
    status.div_done      = div_done;
  end

  // Divider operand selection.
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quotient;

  always_comb begin
    case (cmd.div_sel)
      DIV_BRIGHT: begin
        div_dividend = DIVIDEND_W'(item_sample);
        div_divisor  = (brightness_divisor == '0) ? 10'd1 : brightness_divisor;
      end
      DIV_BAND: begin
        div_dividend = DIVIDEND_W'(x_abs);
        div_divisor  = DIVISOR_W'(band);
      end
      DIV_TIME: begin
        div_dividend = step_time_ms;
        div_divisor  = div_quotient[DIVISOR_W-1:0];
      end
      default: begin
        div_dividend = step_time_ms;
        div_divisor  = 10'd1;
      end
    endcase
  end

  jlcp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.item_take) begin
      item_mode   <= mode_t'(in_item.mode);
      item_sample <= in_item.sample;
    end
  end

  // PWM counter update on a tick.
  logic [COUNT_W-1:0] pwm_inc;
  assign pwm_inc = pwm_count + 1'b1;

  // State updates and configuration writes; writes come last so they win.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time_ms       <= 16'd500;
      dead_band          <= 9'd50;
      pause_threshold    <= 10'd512;
      move_threshold     <= 10'd50;
      pwm_period         <= 16'd100;
      brightness_divisor <= 10'd10;
      led_index          <= '0;
      heading_right      <= 1'b1;
      pwm_count          <= '0;
      on_count           <= 10'd10;
      x_value            <= '0;
      x_at_step          <= '0;
      z_value            <= '0;
      adc_channel        <= CH_X;
      use_phase          <= 1'b0;
      wait_count         <= '0;
      wait_target        <= '0;
      step_due           <= 1'b1;
    end else begin
      if (cmd.apply) begin
        unique case (item_mode)
          MODE_ADC: begin
            if (use_phase) begin
              unique case (adc_channel)
                CH_X: begin
                  x_value     <= {1'b0, item_sample} - X_CENTER;
                  adc_channel <= CH_Z;
                end
                CH_Z: begin
                  z_value     <= item_sample;
                  adc_channel <= CH_Y;
                end
                default: adc_channel <= CH_X;
              endcase
            end
            use_phase <= !use_phase;
          end
          MODE_PWM: begin
            pwm_count <= (pwm_inc >= pwm_period) ? '0 : pwm_inc;
          end
          MODE_MS: begin
            if (paused_now) begin
              step_due <= 1'b1;
            end else if (!step_cond) begin
              wait_count <= wait_inc;
            end else if (!out_band) begin
              // Inside the dead band: keep direction, base wait.
              led_index   <= led_next;
              x_at_step   <= x_value;
              wait_target <= step_time_ms;
              wait_count  <= '0;
              step_due    <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      // Brightness from the Y conversion.
      if (cmd.on_load) begin
        on_count <= div_quotient[9:0];
      end

      // Step with a wait shortened by the joystick deflection.
      if (cmd.step_load) begin
        heading_right <= dir_new;
        led_index     <= led_next;
        x_at_step     <= x_value;
        wait_target   <= div_quotient;
        wait_count    <= '0;
        step_due      <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_STEP_TIME:   step_time_ms       <= cfg_data;
          CFG_DEAD_BAND:   dead_band          <= cfg_data[8:0];
          CFG_PAUSE_THR:   pause_threshold    <= cfg_data[9:0];
          CFG_MOVE_THR:    move_threshold     <= cfg_data[9:0];
          CFG_PWM_PERIOD:  pwm_period         <= cfg_data;
          CFG_BRIGHT_DIV:  brightness_divisor <= cfg_data[9:0];
          CFG_START_RIGHT: heading_right      <= cfg_data[0];
          CFG_START_LED:   led_index          <= led_wrap(cfg_data[2:0]);
          default: ;
        endcase
      end
    end
  end

  // Result register, loaded from the updated state.
  logic             pwm_on;
  logic [4:0]       li_ext;
  logic [MASK_W-1:0] mask;

  always_comb begin
    pwm_on = ({6'd0, on_count} > pwm_count);
    li_ext = 5'(led_index);
    for (int i = 0; i < MASK_W; i++) begin
      mask[i] = pwm_on && (li_ext == 5'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.led_mask     <= mask;
      out_item.active_led   <= li_ext[2:0];
      out_item.moving_right <= heading_right;
      out_item.paused       <= paused_now;
      out_item.next_channel <= adc_channel;
    end
  end

endmodule

`default_nettype wire

[rtl/jlcp_ctrl.sv]
// Controller: sequences each item through apply, divider runs and result load.
// Depends on jlcp_pkg for the command and status structs.
`default_nettype none

module jlcp_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire jlcp_pkg::jlcp_status_t status,
  output jlcp_pkg::jlcp_cmd_t         cmd
);
  import jlcp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV_Y,
    S_DIV_BAND,
    S_DIV_TIME,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Commands decoded from the state and the datapath status.
  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_BRIGHT;
    unique case (state)
      S_IDLE: cmd.item_take = in_valid;
      S_EXEC: begin
        cmd.apply = 1'b1;
        if (status.need_y_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BRIGHT;
        end else if (status.need_step_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BAND;
        end
      end
      S_DIV_Y:    cmd.on_load = status.div_done;
      S_DIV_BAND: begin
        cmd.div_start = status.div_done;
        cmd.div_sel   = DIV_TIME;
      end
      S_DIV_TIME: cmd.step_load = status.div_done;
      S_DONE:     cmd.out_load  = out_free;
      default: ;
    endcase
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result raises valid; an accepted result with no successor drops it.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          if (status.need_y_div) state <= S_DIV_Y;
          else if (status.need_step_div) state <= S_DIV_BAND;
          else state <= S_DONE;
        end
        S_DIV_Y:    if (status.div_done) state <= S_DONE;
        S_DIV_BAND: if (status.div_done) state <= S_DIV_TIME;
        S_DIV_TIME: if (status.div_done) state <= S_DONE;
        S_DONE:     if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/joystick_led_chaser_pwm_core.sv]
// Top level of the joystick LED chaser with PWM dimming.
// Depends on jlcp_pkg, jlcp_ctrl, jlcp_datapath and jlcp_divider.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_item  (mode, sample)
//   out      output     out_valid / out_ready  out_item (led_mask .. next_channel)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// Every item gives one result. PWM ticks, no-op items, discarded, X and Z
// conversions and millisecond ticks without a deflected step use no divider pass.
// A Y conversion takes one pass of the shared bit-serial divider; a step with
// X outside the dead band takes two passes, band and then time. Reset is
// synchronous; the next item is taken while a result waits in the output
// register, and a stalled output holds the block before its next result.
`default_nettype none

module joystick_led_chaser_pwm_core #(
  parameter int LED_COUNT = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire jlcp_pkg::jlcp_in_t               in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output jlcp_pkg::jlcp_out_t                   out_item,
  input  wire logic                             cfg_we,
  input  wire logic [jlcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [jlcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jlcp_pkg::*;

  jlcp_cmd_t    cmd;
  jlcp_status_t status;

  jlcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  jlcp_datapath #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
